// ===== sv/pressure_temp_compensation_defines.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the pressure and temperature compensation block
// Shared property forms, clocked on i_clk and disabled while i_rst_n is low.
// ----------------------------------------------------------------------------
`ifndef PRESSURE_TEMP_COMPENSATION_DEFINES_SVH
`define PRESSURE_TEMP_COMPENSATION_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PTC_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PTC_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/ptc_pkg.sv =====
// ----------------------------------------------------------------------------
// ptc_pkg
// Types, widths, register indexes and helper functions for the compensation.
// ----------------------------------------------------------------------------
package ptc_pkg;

    localparam int RAW_W   = 24;
    localparam int COEF_W  = 16;
    localparam int DT_W    = 25;
    localparam int WIDE_W  = 42;
    localparam int SQ_W    = 50;
    localparam int DEV_W   = 19;
    localparam int DEVSQ_W = 38;
    localparam int TEMP_W  = 24;
    localparam int FULL_W  = 64;
    localparam int PRES_W  = 48;
    localparam int SPLIT   = 19;
    localparam int LO_W    = RAW_W + SPLIT;
    localparam int HI_W    = RAW_W + 1 + WIDE_W - SPLIT;
    localparam int OUT_W   = 32;
    localparam int STAGES  = 9;

    localparam int TEMP_REF = 2000;

    typedef logic        [RAW_W-1:0]   t_raw;
    typedef logic signed [DT_W-1:0]    t_dt;
    typedef logic signed [WIDE_W-1:0]  t_wide;
    typedef logic signed [SQ_W-1:0]    t_sq;
    typedef logic signed [DEV_W-1:0]   t_dev;
    typedef logic signed [DEVSQ_W-1:0] t_devsq;
    typedef logic signed [TEMP_W-1:0]  t_temp;
    typedef logic signed [FULL_W-1:0]  t_full;
    typedef logic signed [PRES_W-1:0]  t_pres;
    typedef logic        [LO_W-1:0]    t_lo;
    typedef logic signed [HI_W-1:0]    t_hi;
    typedef logic signed [OUT_W-1:0]   t_out;

    // Very-low threshold: first-order temperature below -1500 means the
    // deviation from the 2000 reference is below -3500.
    localparam t_dev DEV_VLOW_OFS = 3500;

    localparam t_full SAT_MAX = 64'sd2147483647;
    localparam t_full SAT_MIN = -64'sd2147483648;

    typedef enum logic [2:0] {
        CFG_SENS     = 3'd0,
        CFG_OFF      = 3'd1,
        CFG_TCS      = 3'd2,
        CFG_TCO      = 3'd3,
        CFG_TREF     = 3'd4,
        CFG_TEMPSENS = 3'd5,
        CFG_TWO_BAR  = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [COEF_W-1:0] sens;
        logic [COEF_W-1:0] off;
        logic [COEF_W-1:0] tcs;
        logic [COEF_W-1:0] tco;
        logic [COEF_W-1:0] tref;
        logic [COEF_W-1:0] tempsens;
        logic              two_bar;
    } t_cal;

    // Signed division by 2**k that truncates toward zero.
    function automatic t_full f_trunc_shr(input t_full a, input int unsigned k);
        t_full bias;
        bias = a[FULL_W-1] ? ((64'sd1 <<< k) - 64'sd1) : 64'sd0;
        return (a + bias) >>> k;
    endfunction

    function automatic t_out f_sat32(input t_full a);
        t_out res;
        if (a > SAT_MAX) begin
            res = 32'sh7FFF_FFFF;
        end else if (a < SAT_MIN) begin
            res = 32'sh8000_0000;
        end else begin
            res = a[OUT_W-1:0];
        end
        return res;
    endfunction

endpackage

// ===== sv/ptc_first.sv =====
// ----------------------------------------------------------------------------
// ptc_first
// Stages 1 to 3: temperature difference, calibration products, first order.
// ----------------------------------------------------------------------------
module ptc_first (
    input  logic            i_clk,
    input  logic [2:0]      i_en,
    input  ptc_pkg::t_cal   i_cal,
    input  ptc_pkg::t_raw   i_raw_pressure,
    input  ptc_pkg::t_raw   i_raw_temperature,
    output ptc_pkg::t_raw   o_d1,
    output ptc_pkg::t_wide  o_sens1,
    output ptc_pkg::t_wide  o_off1,
    output ptc_pkg::t_dev   o_dev,
    output ptc_pkg::t_sq    o_dt2
);

    ptc_pkg::t_dt   r_s1_dt,    n_s1_dt;
    ptc_pkg::t_raw  r_s1_d1;
    ptc_pkg::t_wide r_s2_p_tcs, n_s2_p_tcs;
    ptc_pkg::t_wide r_s2_p_tco, n_s2_p_tco;
    ptc_pkg::t_wide r_s2_p_t,   n_s2_p_t;
    ptc_pkg::t_sq   r_s2_dt2,   n_s2_dt2;
    ptc_pkg::t_raw  r_s2_d1;
    ptc_pkg::t_wide r_s3_sens1, n_s3_sens1;
    ptc_pkg::t_wide r_s3_off1,  n_s3_off1;
    ptc_pkg::t_dev  r_s3_dev,   n_s3_dev;
    ptc_pkg::t_sq   r_s3_dt2;
    ptc_pkg::t_raw  r_s3_d1;

    always_comb begin
        n_s1_dt = $signed({1'b0, i_raw_temperature}) - $signed({1'b0, i_cal.tref, 8'h00});
    end

    always_comb begin
        n_s2_p_tcs = ptc_pkg::t_wide'($signed({1'b0, i_cal.tcs}))
                     * ptc_pkg::t_wide'(r_s1_dt);
        n_s2_p_tco = ptc_pkg::t_wide'($signed({1'b0, i_cal.tco}))
                     * ptc_pkg::t_wide'(r_s1_dt);
        n_s2_p_t   = ptc_pkg::t_wide'($signed({1'b0, i_cal.tempsens}))
                     * ptc_pkg::t_wide'(r_s1_dt);
        n_s2_dt2   = ptc_pkg::t_sq'(r_s1_dt) * ptc_pkg::t_sq'(r_s1_dt);
    end

    always_comb begin
        ptc_pkg::t_full v_c1;
        ptc_pkg::t_full v_c2;
        ptc_pkg::t_full v_tcs;
        ptc_pkg::t_full v_tco;
        if (i_cal.two_bar) begin
            v_c1  = $signed(ptc_pkg::t_full'(i_cal.sens) << 16);
            v_c2  = $signed(ptc_pkg::t_full'(i_cal.off) << 17);
            v_tcs = ptc_pkg::f_trunc_shr(ptc_pkg::t_full'(r_s2_p_tcs), 7);
            v_tco = ptc_pkg::f_trunc_shr(ptc_pkg::t_full'(r_s2_p_tco), 6);
        end else begin
            v_c1  = $signed(ptc_pkg::t_full'(i_cal.sens) << 15);
            v_c2  = $signed(ptc_pkg::t_full'(i_cal.off) << 16);
            v_tcs = ptc_pkg::f_trunc_shr(ptc_pkg::t_full'(r_s2_p_tcs), 8);
            v_tco = ptc_pkg::f_trunc_shr(ptc_pkg::t_full'(r_s2_p_tco), 7);
        end
        n_s3_sens1 = ptc_pkg::t_wide'(v_c1 + v_tcs);
        n_s3_off1  = ptc_pkg::t_wide'(v_c2 + v_tco);
        n_s3_dev   = ptc_pkg::t_dev'(ptc_pkg::f_trunc_shr(ptc_pkg::t_full'(r_s2_p_t), 23));
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s1_dt <= n_s1_dt;
            r_s1_d1 <= i_raw_pressure;
        end
        if (i_en[1]) begin
            r_s2_p_tcs <= n_s2_p_tcs;
            r_s2_p_tco <= n_s2_p_tco;
            r_s2_p_t   <= n_s2_p_t;
            r_s2_dt2   <= n_s2_dt2;
            r_s2_d1    <= r_s1_d1;
        end
        if (i_en[2]) begin
            r_s3_sens1 <= n_s3_sens1;
            r_s3_off1  <= n_s3_off1;
            r_s3_dev   <= n_s3_dev;
            r_s3_dt2   <= r_s2_dt2;
            r_s3_d1    <= r_s2_d1;
        end
    end

    assign o_d1    = r_s3_d1;
    assign o_sens1 = r_s3_sens1;
    assign o_off1  = r_s3_off1;
    assign o_dev   = r_s3_dev;
    assign o_dt2   = r_s3_dt2;

endmodule

// ===== sv/ptc_second.sv =====
// ----------------------------------------------------------------------------
// ptc_second
// Stages 4 and 5: squares and the second-order temperature corrections.
// ----------------------------------------------------------------------------
module ptc_second (
    input  logic            i_clk,
    input  logic [1:0]      i_en,
    input  logic            i_two_bar,
    input  ptc_pkg::t_raw   i_d1,
    input  ptc_pkg::t_wide  i_sens1,
    input  ptc_pkg::t_wide  i_off1,
    input  ptc_pkg::t_dev   i_dev,
    input  ptc_pkg::t_sq    i_dt2,
    output ptc_pkg::t_raw   o_d1,
    output ptc_pkg::t_wide  o_sens,
    output ptc_pkg::t_wide  o_off,
    output ptc_pkg::t_temp  o_temp
);

    ptc_pkg::t_devsq r_s4_dev2,  n_s4_dev2;
    ptc_pkg::t_devsq r_s4_v2,    n_s4_v2;
    logic            r_s4_low,   n_s4_low;
    logic            r_s4_vlow,  n_s4_vlow;
    ptc_pkg::t_temp  r_s4_temp,  n_s4_temp;
    ptc_pkg::t_wide  r_s4_sens1;
    ptc_pkg::t_wide  r_s4_off1;
    ptc_pkg::t_raw   r_s4_d1;
    ptc_pkg::t_wide  r_s5_sens,  n_s5_sens;
    ptc_pkg::t_wide  r_s5_off,   n_s5_off;
    ptc_pkg::t_temp  r_s5_temp;
    ptc_pkg::t_raw   r_s5_d1;

    always_comb begin
        ptc_pkg::t_dev  v_v;
        ptc_pkg::t_full v_dt2;
        ptc_pkg::t_full v_t2;
        v_v       = i_dev + ptc_pkg::DEV_VLOW_OFS;
        n_s4_dev2 = ptc_pkg::t_devsq'(i_dev) * ptc_pkg::t_devsq'(i_dev);
        n_s4_v2   = ptc_pkg::t_devsq'(v_v) * ptc_pkg::t_devsq'(v_v);
        n_s4_low  = i_dev[ptc_pkg::DEV_W-1];
        n_s4_vlow = (i_dev < -ptc_pkg::DEV_VLOW_OFS);
        v_dt2     = ptc_pkg::t_full'(i_dt2);
        // The square is never negative, so these divisions are plain shifts.
        if (i_two_bar) begin
            v_t2 = n_s4_low ? ptc_pkg::f_trunc_shr(v_dt2 * 11, 35) : '0;
        end else if (n_s4_low) begin
            v_t2 = ptc_pkg::f_trunc_shr(v_dt2 * 3, 33);
        end else begin
            v_t2 = ptc_pkg::f_trunc_shr(v_dt2 * 2, 37);
        end
        n_s4_temp = ptc_pkg::t_temp'(ptc_pkg::t_full'(ptc_pkg::TEMP_REF)
                    + ptc_pkg::t_full'(i_dev) - v_t2);
    end

    always_comb begin
        ptc_pkg::t_full v_dev2;
        ptc_pkg::t_full v_v2;
        ptc_pkg::t_full v_off2;
        ptc_pkg::t_full v_sens2;
        v_dev2 = ptc_pkg::t_full'(r_s4_dev2);
        v_v2   = ptc_pkg::t_full'(r_s4_v2);
        priority if (i_two_bar && r_s4_low) begin
            v_off2  = ptc_pkg::f_trunc_shr(v_dev2 * 31, 3);
            v_sens2 = ptc_pkg::f_trunc_shr(v_dev2 * 63, 5);
        end else if (i_two_bar) begin
            v_off2  = '0;
            v_sens2 = '0;
        end else if (r_s4_low) begin
            v_off2  = ptc_pkg::f_trunc_shr(v_dev2 * 3, 1)
                      + (r_s4_vlow ? v_v2 * 7 : 64'sd0);
            v_sens2 = ptc_pkg::f_trunc_shr(v_dev2 * 5, 3)
                      + (r_s4_vlow ? v_v2 * 4 : 64'sd0);
        end else begin
            v_off2  = ptc_pkg::f_trunc_shr(v_dev2, 4);
            v_sens2 = '0;
        end
        n_s5_sens = ptc_pkg::t_wide'(ptc_pkg::t_full'(r_s4_sens1) - v_sens2);
        n_s5_off  = ptc_pkg::t_wide'(ptc_pkg::t_full'(r_s4_off1) - v_off2);
    end

    always_ff @(posedge i_clk) begin
        if (i_en[0]) begin
            r_s4_dev2  <= n_s4_dev2;
            r_s4_v2    <= n_s4_v2;
            r_s4_low   <= n_s4_low;
            r_s4_vlow  <= n_s4_vlow;
            r_s4_temp  <= n_s4_temp;
            r_s4_sens1 <= i_sens1;
            r_s4_off1  <= i_off1;
            r_s4_d1    <= i_d1;
        end
        if (i_en[1]) begin
            r_s5_sens <= n_s5_sens;
            r_s5_off  <= n_s5_off;
            r_s5_temp <= r_s4_temp;
            r_s5_d1   <= r_s4_d1;
        end
    end

    assign o_d1   = r_s5_d1;
    assign o_sens = r_s5_sens;
    assign o_off  = r_s5_off;
    assign o_temp = r_s5_temp;

endmodule

// ===== sv/pressure_temp_compensation.sv =====
// ----------------------------------------------------------------------------
// pressure_temp_compensation
// Second-order temperature compensation of raw barometric sensor conversions.
// ----------------------------------------------------------------------------
//
//  Channel  Direction  Handshake                  Payload
//  -------  ---------  -------------------------  ------------------------------
//  input    in         i_in_valid / o_in_stall    i_raw_pressure, i_raw_temperature
//  output   out        o_out_valid / i_out_stall  o_temperature_centi, o_pressure_value
//  config   in         i_cfg_wr_en                i_cfg_index, i_cfg_wdata
//
//  One item is taken per clock cycle while o_in_stall is low; each result
//  is presented once its item has passed every stage. The depth comes from
//  three multiplier ranks (the calibration products with the square of dT,
//  the deviation squares, and the split 24 by 42 bit pressure product),
//  each followed by its own add or shift stage.
//  Reset clears the calibration registers and all stage valid bits at once.
//  A stall on the output holds only the full stages at the end of the pipe;
//  empty stages upstream still fill, so the input stalls only when every
//  stage holds an item.
//
`include "pressure_temp_compensation_defines.svh"

module pressure_temp_compensation (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [ptc_pkg::RAW_W-1:0]     i_raw_pressure,
    input  logic [ptc_pkg::RAW_W-1:0]     i_raw_temperature,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic signed [ptc_pkg::OUT_W-1:0] o_temperature_centi,
    output logic signed [ptc_pkg::OUT_W-1:0] o_pressure_value,
    input  logic                          i_cfg_wr_en,
    input  logic [2:0]                    i_cfg_index,
    input  logic [ptc_pkg::COEF_W-1:0]    i_cfg_wdata
);

    // Calibration words and model select. The user must change these only while
    // the pipeline is empty (the block does not enforce it); every stage reads them directly.
    ptc_pkg::t_cal r_cal;

    // One valid bit per stage; stage 9 is the output register.
    logic [ptc_pkg::STAGES-1:0] r_vld, n_vld;
    logic [ptc_pkg::STAGES-1:0] w_en;

    ptc_pkg::t_raw  w_s3_d1;
    ptc_pkg::t_wide w_s3_sens1;
    ptc_pkg::t_wide w_s3_off1;
    ptc_pkg::t_dev  w_s3_dev;
    ptc_pkg::t_sq   w_s3_dt2;
    ptc_pkg::t_raw  w_s5_d1;
    ptc_pkg::t_wide w_s5_sens;
    ptc_pkg::t_wide w_s5_off;
    ptc_pkg::t_temp w_s5_temp;

    ptc_pkg::t_lo   r_s6_pl,   n_s6_pl;
    ptc_pkg::t_hi   r_s6_ph,   n_s6_ph;
    ptc_pkg::t_wide r_s6_off;
    ptc_pkg::t_temp r_s6_temp;
    ptc_pkg::t_full r_s7_prod, n_s7_prod;
    ptc_pkg::t_wide r_s7_off;
    ptc_pkg::t_temp r_s7_temp;
    ptc_pkg::t_pres r_s8_p1,   n_s8_p1;
    ptc_pkg::t_temp r_s8_temp;
    ptc_pkg::t_out  r_out_temp, n_out_temp;
    ptc_pkg::t_out  r_out_pres, n_out_pres;

    // ------------------------------------------------------------------
    // Configuration writes. An index past the last register is ignored.
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cal <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                ptc_pkg::CFG_SENS:     r_cal.sens     <= i_cfg_wdata;
                ptc_pkg::CFG_OFF:      r_cal.off      <= i_cfg_wdata;
                ptc_pkg::CFG_TCS:      r_cal.tcs      <= i_cfg_wdata;
                ptc_pkg::CFG_TCO:      r_cal.tco      <= i_cfg_wdata;
                ptc_pkg::CFG_TREF:     r_cal.tref     <= i_cfg_wdata;
                ptc_pkg::CFG_TEMPSENS: r_cal.tempsens <= i_cfg_wdata;
                ptc_pkg::CFG_TWO_BAR:  r_cal.two_bar  <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline flow control. A stage loads when it is empty or when the
    // stage after it loads in the same cycle.
    // ------------------------------------------------------------------
    always_comb begin
        w_en[ptc_pkg::STAGES-1] = !r_vld[ptc_pkg::STAGES-1] || !i_out_stall;
        for (int k = ptc_pkg::STAGES - 2; k >= 0; k--) begin
            w_en[k] = !r_vld[k] || w_en[k+1];
        end
    end

    always_comb begin
        n_vld[0] = w_en[0] ? i_in_valid : r_vld[0];
        for (int k = 1; k < ptc_pkg::STAGES; k++) begin
            n_vld[k] = w_en[k] ? r_vld[k-1] : r_vld[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_in_stall  = !w_en[0];
    assign o_out_valid = r_vld[ptc_pkg::STAGES-1];

    // ------------------------------------------------------------------
    // Stages 1 to 5: first-order terms and second-order corrections.
    // ------------------------------------------------------------------
    ptc_first u_first (
        .i_clk             (i_clk),
        .i_en              (w_en[2:0]),
        .i_cal             (r_cal),
        .i_raw_pressure    (i_raw_pressure),
        .i_raw_temperature (i_raw_temperature),
        .o_d1              (w_s3_d1),
        .o_sens1           (w_s3_sens1),
        .o_off1            (w_s3_off1),
        .o_dev             (w_s3_dev),
        .o_dt2             (w_s3_dt2)
    );

    ptc_second u_second (
        .i_clk     (i_clk),
        .i_en      (w_en[4:3]),
        .i_two_bar (r_cal.two_bar),
        .i_d1      (w_s3_d1),
        .i_sens1   (w_s3_sens1),
        .i_off1    (w_s3_off1),
        .i_dev     (w_s3_dev),
        .i_dt2     (w_s3_dt2),
        .o_d1      (w_s5_d1),
        .o_sens    (w_s5_sens),
        .o_off     (w_s5_off),
        .o_temp    (w_s5_temp)
    );

    // ------------------------------------------------------------------
    // Stage 6: the pressure product D1 * SENS is split into two partial
    // products, the low sensitivity bits unsigned and the high bits signed.
    // ------------------------------------------------------------------
    always_comb begin
        n_s6_pl = ptc_pkg::t_lo'(w_s5_d1)
                  * ptc_pkg::t_lo'(w_s5_sens[ptc_pkg::SPLIT-1:0]);
        n_s6_ph = ptc_pkg::t_hi'($signed({1'b0, w_s5_d1}))
                  * ptc_pkg::t_hi'($signed(w_s5_sens[ptc_pkg::WIDE_W-1:ptc_pkg::SPLIT]));
    end

    // Stage 7: recombine the partial products into the full product.
    always_comb begin
        n_s7_prod = (ptc_pkg::t_full'(r_s6_ph) <<< ptc_pkg::SPLIT)
                    + ptc_pkg::t_full'(r_s6_pl);
    end

    // Stage 8: scale the product by 2**21 with truncation, remove offset.
    always_comb begin
        n_s8_p1 = ptc_pkg::t_pres'(ptc_pkg::f_trunc_shr(r_s7_prod, 21)
                  - ptc_pkg::t_full'(r_s7_off));
    end

    // Stage 9: final scale for the selected model and saturation.
    always_comb begin
        n_out_pres = ptc_pkg::f_sat32(ptc_pkg::f_trunc_shr(
                         ptc_pkg::t_full'(r_s8_p1), r_cal.two_bar ? 15 : 13));
        n_out_temp = ptc_pkg::f_sat32(ptc_pkg::t_full'(r_s8_temp));
    end

    always_ff @(posedge i_clk) begin
        if (w_en[5]) begin
            r_s6_pl   <= n_s6_pl;
            r_s6_ph   <= n_s6_ph;
            r_s6_off  <= w_s5_off;
            r_s6_temp <= w_s5_temp;
        end
        if (w_en[6]) begin
            r_s7_prod <= n_s7_prod;
            r_s7_off  <= r_s6_off;
            r_s7_temp <= r_s6_temp;
        end
        if (w_en[7]) begin
            r_s8_p1   <= n_s8_p1;
            r_s8_temp <= r_s7_temp;
        end
        if (w_en[8]) begin
            r_out_temp <= n_out_temp;
            r_out_pres <= n_out_pres;
        end
    end

    assign o_temperature_centi = r_out_temp;
    assign o_pressure_value    = r_out_pres;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    `PTC_ASSERT_SAME(a_drain_no_stall, !o_out_valid || !i_out_stall, !o_in_stall, "input stalled")
    `PTC_ASSERT_NEXT(a_accept_fills_s1, i_in_valid && !o_in_stall, r_vld[0], "accepted item lost")
    `PTC_ASSERT_SAME(a_result_from_s8, $rose(o_out_valid), $past(r_vld[7]), "orphan result")

endmodule
